FILE: hdl/rv64enc_pkg.sv
// Package: word types, mnemonic codes, format kinds and the base-form table of the RV64I encoder.
`timescale 1ns / 1ps
package rv64enc_pkg;

  // Default depth of the queue between decode and encode
  localparam int QUEUE_DEPTH = 2;

  // Number of mnemonics that map straight onto one base form
  localparam logic [6:0] BASE_COUNT = 7'd52;

  // Major opcodes
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPI    = 7'h13;
  localparam logic [6:0] OPC_OP32   = 7'h3B;
  localparam logic [6:0] OPC_OPI32  = 7'h1B;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_MISC   = 7'h0F;

  // Common funct7 values
  localparam logic [6:0] F7_NONE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_BRK  = 7'h01;

  // funct3 values used by pseudo-instructions
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [4:0] REG_ZERO = 5'd0;

  // Mnemonic codes carried in the request
  typedef enum logic [6:0] {
    MN_ADD, MN_ADDI, MN_ADDW, MN_ADDIW, MN_SUB, MN_SUBW, MN_AND, MN_ANDI,
    MN_OR, MN_ORI, MN_XOR, MN_XORI, MN_SLL, MN_SLLI, MN_SLLW, MN_SLLIW,
    MN_SRL, MN_SRLI, MN_SRLW, MN_SRLIW, MN_SRA, MN_SRAI, MN_SRAW, MN_SRAIW,
    MN_SLT, MN_SLTI, MN_SLTU, MN_SLTIU, MN_BEQ, MN_BNE, MN_BGE, MN_BGEU,
    MN_BLT, MN_BLTU, MN_JAL, MN_JALR, MN_ECALL, MN_EBREAK, MN_LB, MN_LH,
    MN_LW, MN_LD, MN_LBU, MN_LHU, MN_LWU, MN_SB, MN_SH, MN_SW, MN_SD,
    MN_LUI, MN_AUIPC, MN_FENCE, MN_NOP, MN_LI, MN_LA, MN_MV, MN_NOT,
    MN_NEG, MN_NEGW, MN_SEXT_W, MN_SEQZ, MN_SNEZ, MN_SLTZ, MN_SGTZ,
    MN_BEQZ, MN_BNEZ, MN_BLEZ, MN_BGEZ, MN_BLTZ, MN_BGTZ, MN_BGT, MN_BLE,
    MN_BGTU, MN_BLEU
  } mnemonic_t;

  // Encoding format of a decoded operation
  typedef enum logic [3:0] {
    KIND_R, KIND_I, KIND_SH, KIND_SHW, KIND_S, KIND_B, KIND_J, KIND_U,
    KIND_SYS, KIND_FENCE, KIND_PAIR
  } kind_t;

  // Request word
  typedef struct packed {
    logic [6:0]         opcode;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [31:0] immediate;
    logic [31:0]        label_address;
    logic [31:0]        position;
  } req_word_t;

  // Result word
  typedef struct packed {
    logic [31:0] machine_word;
    logic        last;
  } enc_word_t;

  // Base form of a mnemonic
  typedef struct packed {
    kind_t      kind;
    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
  } base_form_t;

  // Decoded operation passed from decode to encode
  typedef struct packed {
    kind_t       kind;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] val;
  } dec_op_t;

  function automatic base_form_t mk(kind_t k, logic [6:0] o, logic [2:0] f3,
                                    logic [6:0] f7);
    base_form_t b;
    b.kind = k;
    b.opc  = o;
    b.f3   = f3;
    b.f7   = f7;
    return b;
  endfunction

  // Base-form table, one entry per base mnemonic
  function automatic base_form_t base_lookup(mnemonic_t mn);
    base_form_t b;
    b = mk(KIND_I, OPC_OPI, 3'd0, F7_NONE);
    unique case (mn)
      MN_ADD:    b = mk(KIND_R,     OPC_OP,     3'd0, F7_NONE);
      MN_ADDI:   b = mk(KIND_I,     OPC_OPI,    3'd0, F7_NONE);
      MN_ADDW:   b = mk(KIND_R,     OPC_OP32,   3'd0, F7_NONE);
      MN_ADDIW:  b = mk(KIND_I,     OPC_OPI32,  3'd0, F7_NONE);
      MN_SUB:    b = mk(KIND_R,     OPC_OP,     3'd0, F7_ALT);
      MN_SUBW:   b = mk(KIND_R,     OPC_OP32,   3'd0, F7_ALT);
      MN_AND:    b = mk(KIND_R,     OPC_OP,     3'd7, F7_NONE);
      MN_ANDI:   b = mk(KIND_I,     OPC_OPI,    3'd7, F7_NONE);
      MN_OR:     b = mk(KIND_R,     OPC_OP,     3'd6, F7_NONE);
      MN_ORI:    b = mk(KIND_I,     OPC_OPI,    3'd6, F7_NONE);
      MN_XOR:    b = mk(KIND_R,     OPC_OP,     3'd4, F7_NONE);
      MN_XORI:   b = mk(KIND_I,     OPC_OPI,    3'd4, F7_NONE);
      MN_SLL:    b = mk(KIND_R,     OPC_OP,     3'd1, F7_NONE);
      MN_SLLI:   b = mk(KIND_SH,    OPC_OPI,    3'd1, F7_NONE);
      MN_SLLW:   b = mk(KIND_R,     OPC_OP32,   3'd1, F7_NONE);
      MN_SLLIW:  b = mk(KIND_SHW,   OPC_OPI32,  3'd1, F7_NONE);
      MN_SRL:    b = mk(KIND_R,     OPC_OP,     3'd5, F7_NONE);
      MN_SRLI:   b = mk(KIND_SH,    OPC_OPI,    3'd5, F7_NONE);
      MN_SRLW:   b = mk(KIND_R,     OPC_OP32,   3'd5, F7_NONE);
      MN_SRLIW:  b = mk(KIND_SHW,   OPC_OPI32,  3'd5, F7_NONE);
      MN_SRA:    b = mk(KIND_R,     OPC_OP,     3'd5, F7_ALT);
      MN_SRAI:   b = mk(KIND_SH,    OPC_OPI,    3'd5, F7_ALT);
      MN_SRAW:   b = mk(KIND_R,     OPC_OP32,   3'd5, F7_ALT);
      MN_SRAIW:  b = mk(KIND_SHW,   OPC_OPI32,  3'd5, F7_ALT);
      MN_SLT:    b = mk(KIND_R,     OPC_OP,     3'd2, F7_NONE);
      MN_SLTI:   b = mk(KIND_I,     OPC_OPI,    3'd2, F7_NONE);
      MN_SLTU:   b = mk(KIND_R,     OPC_OP,     3'd3, F7_NONE);
      MN_SLTIU:  b = mk(KIND_I,     OPC_OPI,    3'd3, F7_NONE);
      MN_BEQ:    b = mk(KIND_B,     OPC_BRANCH, 3'd0, F7_NONE);
      MN_BNE:    b = mk(KIND_B,     OPC_BRANCH, 3'd1, F7_NONE);
      MN_BGE:    b = mk(KIND_B,     OPC_BRANCH, 3'd5, F7_NONE);
      MN_BGEU:   b = mk(KIND_B,     OPC_BRANCH, 3'd7, F7_NONE);
      MN_BLT:    b = mk(KIND_B,     OPC_BRANCH, 3'd4, F7_NONE);
      MN_BLTU:   b = mk(KIND_B,     OPC_BRANCH, 3'd6, F7_NONE);
      MN_JAL:    b = mk(KIND_J,     OPC_JAL,    3'd0, F7_NONE);
      MN_JALR:   b = mk(KIND_I,     OPC_JALR,   3'd0, F7_NONE);
      MN_ECALL:  b = mk(KIND_SYS,   OPC_SYSTEM, 3'd0, F7_NONE);
      MN_EBREAK: b = mk(KIND_SYS,   OPC_SYSTEM, 3'd0, F7_BRK);
      MN_LB:     b = mk(KIND_I,     OPC_LOAD,   3'd0, F7_NONE);
      MN_LH:     b = mk(KIND_I,     OPC_LOAD,   3'd1, F7_NONE);
      MN_LW:     b = mk(KIND_I,     OPC_LOAD,   3'd2, F7_NONE);
      MN_LD:     b = mk(KIND_I,     OPC_LOAD,   3'd3, F7_NONE);
      MN_LBU:    b = mk(KIND_I,     OPC_LOAD,   3'd4, F7_NONE);
      MN_LHU:    b = mk(KIND_I,     OPC_LOAD,   3'd5, F7_NONE);
      MN_LWU:    b = mk(KIND_I,     OPC_LOAD,   3'd6, F7_NONE);
      MN_SB:     b = mk(KIND_S,     OPC_STORE,  3'd0, F7_NONE);
      MN_SH:     b = mk(KIND_S,     OPC_STORE,  3'd1, F7_NONE);
      MN_SW:     b = mk(KIND_S,     OPC_STORE,  3'd2, F7_NONE);
      MN_SD:     b = mk(KIND_S,     OPC_STORE,  3'd3, F7_NONE);
      MN_LUI:    b = mk(KIND_U,     OPC_LUI,    3'd0, F7_NONE);
      MN_AUIPC:  b = mk(KIND_U,     OPC_AUIPC,  3'd0, F7_NONE);
      MN_FENCE:  b = mk(KIND_FENCE, OPC_MISC,   3'd0, F7_NONE);
      default:   b = mk(KIND_I,     OPC_OPI,    3'd0, F7_NONE);
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/rv64enc_front.sv
// Decode stage: accepts request words and classifies them into encoder operations.
`timescale 1ns / 1ps
module rv64enc_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rv64enc_pkg::req_word_t in_word,
  input  logic                  full,
  output logic                  push,
  output rv64enc_pkg::dec_op_t  op
);
  import rv64enc_pkg::*;

  logic       known;
  logic [31:0] rel;
  mnemonic_t  mn;
  base_form_t bf;

  // Hold off requests while the queue has no room
  assign in_stall = full;
  assign push     = in_valid && !full && known;

  // pc-relative distance, modulo 2^32
  assign rel = in_word.label_address - in_word.position;
  assign mn  = mnemonic_t'(in_word.opcode);
  assign bf  = base_lookup(mn);

  // Classify: base forms from the table, pseudos rewritten in place
  always_comb begin
    known  = 1'b1;
    op.kind = KIND_I;
    op.opc  = OPC_OPI;
    op.f3   = F3_ADD;
    op.f7   = F7_NONE;
    op.rd   = in_word.dest_reg;
    op.rs1  = in_word.src_reg_a;
    op.rs2  = in_word.src_reg_b;
    op.val  = in_word.immediate;
    if (in_word.opcode < BASE_COUNT) begin
      op.kind = bf.kind;
      op.opc  = bf.opc;
      op.f3   = bf.f3;
      op.f7   = bf.f7;
      if (bf.kind == KIND_B || bf.kind == KIND_J) begin
        op.val = rel;
      end
    end else begin
      unique case (mn)
        MN_NOP: begin
          op.rd  = REG_ZERO;
          op.rs1 = REG_ZERO;
          op.val = 32'd0;
        end
        MN_LI: begin
          op.kind = KIND_PAIR;
          op.opc  = OPC_LUI;
        end
        MN_LA: begin
          op.kind = KIND_PAIR;
          op.opc  = OPC_AUIPC;
          op.val  = rel;
        end
        MN_MV: begin
          op.val = 32'd0;
        end
        MN_NOT: begin
          op.f3  = F3_XOR;
          op.val = 32'hFFF;
        end
        MN_NEG, MN_NEGW, MN_SNEZ, MN_SGTZ: begin
          op.kind = KIND_R;
          op.opc  = (mn == MN_NEGW) ? OPC_OP32 : OPC_OP;
          op.f7   = (mn == MN_NEG || mn == MN_NEGW) ? F7_ALT : F7_NONE;
          op.f3   = (mn == MN_SNEZ) ? F3_SLTU :
                    (mn == MN_SGTZ) ? F3_SLT : F3_ADD;
          op.rs1  = REG_ZERO;
          op.rs2  = in_word.src_reg_a;
        end
        MN_SEXT_W: begin
          op.opc = OPC_OPI32;
          op.val = 32'd0;
        end
        MN_SEQZ: begin
          op.f3  = F3_SLTU;
          op.val = 32'd1;
        end
        MN_SLTZ: begin
          op.kind = KIND_R;
          op.opc  = OPC_OP;
          op.f3   = F3_SLT;
          op.rs2  = REG_ZERO;
        end
        // Branches against zero: register on rs1 or rs2 side
        MN_BEQZ, MN_BNEZ, MN_BGEZ, MN_BLTZ, MN_BLEZ, MN_BGTZ: begin
          op.kind = KIND_B;
          op.opc  = OPC_BRANCH;
          op.val  = rel;
          op.f3   = (mn == MN_BEQZ) ? F3_BEQ :
                    (mn == MN_BNEZ) ? F3_BNE :
                    (mn == MN_BGEZ || mn == MN_BLEZ) ? F3_BGE : F3_BLT;
          if (mn == MN_BLEZ || mn == MN_BGTZ) begin
            op.rs1 = REG_ZERO;
            op.rs2 = in_word.src_reg_a;
          end else begin
            op.rs1 = in_word.src_reg_a;
            op.rs2 = REG_ZERO;
          end
        end
        // Swapped-operand branches
        MN_BGT, MN_BLE, MN_BGTU, MN_BLEU: begin
          op.kind = KIND_B;
          op.opc  = OPC_BRANCH;
          op.val  = rel;
          op.f3   = (mn == MN_BGT) ? F3_BLT :
                    (mn == MN_BLE) ? F3_BGE :
                    (mn == MN_BGTU) ? F3_BLTU : F3_BGEU;
          op.rs1  = in_word.src_reg_b;
          op.rs2  = in_word.src_reg_a;
        end
        default: begin
          known = 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: hdl/rv64enc_queue.sv
// Small FIFO of decoded operations between decode and encode.
`timescale 1ns / 1ps
module rv64enc_queue #(
  parameter int DEPTH = rv64enc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rv64enc_pkg::dec_op_t push_op,
  input  logic                 pop,
  output logic                 head_valid,
  output rv64enc_pkg::dec_op_t head_op,
  output logic                 full
);
  import rv64enc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dec_op_t            entries [DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [CNT_W-1:0]   count;

  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(DEPTH));
  assign head_op    = entries[head];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

FILE: hdl/rv64enc_back.sv
// Encode stage: packs decoded operations into machine words behind an output register.
`timescale 1ns / 1ps
module rv64enc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  rv64enc_pkg::dec_op_t   head_op,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rv64enc_pkg::enc_word_t out_word
);
  import rv64enc_pkg::*;

  logic        phase;
  logic        load;
  logic        emit;
  logic        is_pair;
  logic [31:0] upper;
  logic [31:0] word;

  assign load    = !out_valid || !out_stall;
  assign emit    = head_valid && load;
  assign is_pair = (head_op.kind == KIND_PAIR);
  assign pop     = emit && (!is_pair || phase);

  // Upper part of li/la with the rounding carry of the low 12 bits
  assign upper = head_op.val + 32'h800;

  // Field packing per format
  always_comb begin
    unique case (head_op.kind)
      KIND_R: word = {head_op.f7, head_op.rs2, head_op.rs1, head_op.f3, head_op.rd,
                      head_op.opc};
      KIND_I: word = {head_op.val[11:0], head_op.rs1, head_op.f3, head_op.rd,
                      head_op.opc};
      KIND_SH: word = {6'd0, head_op.val[5:0], head_op.rs1, head_op.f3, head_op.rd,
                       head_op.opc} | {head_op.f7, 25'd0};
      KIND_SHW: word = {7'd0, head_op.val[4:0], head_op.rs1, head_op.f3, head_op.rd,
                        head_op.opc} | {head_op.f7, 25'd0};
      KIND_S: word = {head_op.val[11:5], head_op.rs2, head_op.rs1, head_op.f3,
                      head_op.val[4:0], head_op.opc};
      KIND_B: word = {head_op.val[12], head_op.val[10:5], head_op.rs2, head_op.rs1,
                      head_op.f3, head_op.val[4:1], head_op.val[11], head_op.opc};
      KIND_J: word = {head_op.val[20], head_op.val[10:1], head_op.val[11],
                      head_op.val[19:12], head_op.rd, head_op.opc};
      KIND_U: word = {head_op.val[31:12], head_op.rd, head_op.opc};
      KIND_SYS: word = {5'd0, head_op.f7, 13'd0, head_op.opc};
      KIND_FENCE: word = {head_op.val[11:0], 13'd0, head_op.opc};
      KIND_PAIR: begin
        if (!phase) begin
          word = {upper[31:12], head_op.rd, head_op.opc};
        end else begin
          word = {head_op.val[11:0], head_op.rd, F3_ADD, head_op.rd, OPC_OPI};
        end
      end
      default: word = 32'd0;
    endcase
  end

  // Output register and pair phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= head_valid;
      end
      if (emit) begin
        phase <= is_pair && !phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word.machine_word <= word;
      out_word.last         <= !(is_pair && !phase);
    end
  end

  a_phase_head: assert property (@(posedge clk) disable iff (rst)
    phase |-> (head_valid && head_op.kind == KIND_PAIR))
    else $error("second phase without a pair operation at the head");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_word.last) |=> (out_valid && out_word.last))
    else $error("second word of a pair did not follow");

  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && out_word.last))
    else $error("operation retired without a last word");

endmodule

FILE: hdl/rv64i_instruction_encoder_top.sv
// An accepted request enters the queue; its first word then enters the output register.
// Throughput: one request per cycle; li and la give two output words, the queue absorbs
// the extra word and the input stalls only when the queue is full.
// The output register carries one word per cycle when out_stall is low.
// Reset (rst, synchronous) empties the queue and clears the output valid.
`timescale 1ns / 1ps
module rv64i_instruction_encoder_top #(
  parameter int QUEUE_DEPTH = rv64enc_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rv64enc_pkg::req_word_t in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rv64enc_pkg::enc_word_t out_word
);
  import rv64enc_pkg::*;

  logic    full;
  logic    push;
  logic    pop;
  logic    head_valid;
  dec_op_t push_op;
  dec_op_t head_op;

  // Decode
  rv64enc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .full     (full),
    .push     (push),
    .op       (push_op)
  );

  // Decoupling queue
  rv64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op),
    .full       (full)
  );

  // Encode
  rv64enc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

FILE: test/rv64i_instruction_encoder_top_tb.sv
// Self-checking testbench for the RV64I instruction encoder: directed and random requests.
`timescale 1ns / 1ps
module rv64i_instruction_encoder_top_tb;
  import rv64enc_pkg::*;

  localparam logic [6:0] CODE_LIMIT = 7'd74;   // first code with no encoding
  localparam logic [6:0] CODE_MAX   = 7'd127;
  localparam int         LONG_HOLD  = 120;
  localparam int         DRAIN_CYCLES = 8;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  req_word_t in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  enc_word_t out_word;

  enc_word_t   expected_words[$];
  enc_word_t   want;
  int          error_count = 0;
  int          burst_left = 0;
  bit          sender_gaps = 1'b1;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_run = 0;
  bit          stall_busy = 1'b0;
  int          hold_left = 0;
  bit          hold_request = 1'b0;

  rv64i_instruction_encoder_top uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #4 clk = ~clk;

  // Format packers
  function automatic logic [31:0] fmt_r(logic [6:0] op, logic [2:0] f3, logic [6:0] f7,
                                        logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] fmt_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [31:0] imm);
    return {imm[11:0], rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] fmt_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [31:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] fmt_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [31:0] off);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] fmt_j(logic [4:0] rd, logic [31:0] off);
    return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] fmt_u(logic [6:0] op, logic [4:0] rd, logic [31:0] val);
    return {val[31:12], rd, op};
  endfunction

  // Shift-immediate: amount in the low immediate bits, funct7 on top
  function automatic logic [31:0] fmt_sh(logic [6:0] op, logic [2:0] f3, logic [6:0] f7,
                                         logic [4:0] rd, logic [4:0] rs1, logic [5:0] amt);
    return fmt_i(op, f3, rd, rs1, {26'd0, amt}) | {f7, 25'd0};
  endfunction

  // Works out the machine words of one request and queues them
  function automatic void predict_words(req_word_t r);
    logic [31:0] rel, imm, v, w;
    logic [4:0]  rd, ra, rb;
    enc_word_t   e;
    rel = r.label_address - r.position;
    imm = r.immediate;
    rd  = r.dest_reg;
    ra  = r.src_reg_a;
    rb  = r.src_reg_b;
    w   = '0;
    if (r.opcode >= CODE_LIMIT) return;
    case (mnemonic_t'(r.opcode))
      MN_ADD:    w = fmt_r(OPC_OP, 3'd0, F7_NONE, rd, ra, rb);
      MN_ADDI:   w = fmt_i(OPC_OPI, 3'd0, rd, ra, imm);
      MN_ADDW:   w = fmt_r(OPC_OP32, 3'd0, F7_NONE, rd, ra, rb);
      MN_ADDIW:  w = fmt_i(OPC_OPI32, 3'd0, rd, ra, imm);
      MN_SUB:    w = fmt_r(OPC_OP, 3'd0, F7_ALT, rd, ra, rb);
      MN_SUBW:   w = fmt_r(OPC_OP32, 3'd0, F7_ALT, rd, ra, rb);
      MN_AND:    w = fmt_r(OPC_OP, 3'd7, F7_NONE, rd, ra, rb);
      MN_ANDI:   w = fmt_i(OPC_OPI, 3'd7, rd, ra, imm);
      MN_OR:     w = fmt_r(OPC_OP, 3'd6, F7_NONE, rd, ra, rb);
      MN_ORI:    w = fmt_i(OPC_OPI, 3'd6, rd, ra, imm);
      MN_XOR:    w = fmt_r(OPC_OP, 3'd4, F7_NONE, rd, ra, rb);
      MN_XORI:   w = fmt_i(OPC_OPI, 3'd4, rd, ra, imm);
      MN_SLL:    w = fmt_r(OPC_OP, 3'd1, F7_NONE, rd, ra, rb);
      MN_SLLI:   w = fmt_sh(OPC_OPI, 3'd1, F7_NONE, rd, ra, imm[5:0]);
      MN_SLLW:   w = fmt_r(OPC_OP32, 3'd1, F7_NONE, rd, ra, rb);
      MN_SLLIW:  w = fmt_sh(OPC_OPI32, 3'd1, F7_NONE, rd, ra, {1'b0, imm[4:0]});
      MN_SRL:    w = fmt_r(OPC_OP, 3'd5, F7_NONE, rd, ra, rb);
      MN_SRLI:   w = fmt_sh(OPC_OPI, 3'd5, F7_NONE, rd, ra, imm[5:0]);
      MN_SRLW:   w = fmt_r(OPC_OP32, 3'd5, F7_NONE, rd, ra, rb);
      MN_SRLIW:  w = fmt_sh(OPC_OPI32, 3'd5, F7_NONE, rd, ra, {1'b0, imm[4:0]});
      MN_SRA:    w = fmt_r(OPC_OP, 3'd5, F7_ALT, rd, ra, rb);
      MN_SRAI:   w = fmt_sh(OPC_OPI, 3'd5, F7_ALT, rd, ra, imm[5:0]);
      MN_SRAW:   w = fmt_r(OPC_OP32, 3'd5, F7_ALT, rd, ra, rb);
      MN_SRAIW:  w = fmt_sh(OPC_OPI32, 3'd5, F7_ALT, rd, ra, {1'b0, imm[4:0]});
      MN_SLT:    w = fmt_r(OPC_OP, F3_SLT, F7_NONE, rd, ra, rb);
      MN_SLTI:   w = fmt_i(OPC_OPI, F3_SLT, rd, ra, imm);
      MN_SLTU:   w = fmt_r(OPC_OP, F3_SLTU, F7_NONE, rd, ra, rb);
      MN_SLTIU:  w = fmt_i(OPC_OPI, F3_SLTU, rd, ra, imm);
      MN_BEQ:    w = fmt_b(F3_BEQ, ra, rb, rel);
      MN_BNE:    w = fmt_b(F3_BNE, ra, rb, rel);
      MN_BGE:    w = fmt_b(F3_BGE, ra, rb, rel);
      MN_BGEU:   w = fmt_b(F3_BGEU, ra, rb, rel);
      MN_BLT:    w = fmt_b(F3_BLT, ra, rb, rel);
      MN_BLTU:   w = fmt_b(F3_BLTU, ra, rb, rel);
      MN_JAL:    w = fmt_j(rd, rel);
      MN_JALR:   w = fmt_i(OPC_JALR, 3'd0, rd, ra, imm);
      MN_ECALL:  w = {25'd0, OPC_SYSTEM};
      MN_EBREAK: w = {5'd0, F7_BRK, 13'd0, OPC_SYSTEM};
      MN_LB:     w = fmt_i(OPC_LOAD, 3'd0, rd, ra, imm);
      MN_LH:     w = fmt_i(OPC_LOAD, 3'd1, rd, ra, imm);
      MN_LW:     w = fmt_i(OPC_LOAD, 3'd2, rd, ra, imm);
      MN_LD:     w = fmt_i(OPC_LOAD, 3'd3, rd, ra, imm);
      MN_LBU:    w = fmt_i(OPC_LOAD, 3'd4, rd, ra, imm);
      MN_LHU:    w = fmt_i(OPC_LOAD, 3'd5, rd, ra, imm);
      MN_LWU:    w = fmt_i(OPC_LOAD, 3'd6, rd, ra, imm);
      MN_SB:     w = fmt_s(3'd0, ra, rb, imm);
      MN_SH:     w = fmt_s(3'd1, ra, rb, imm);
      MN_SW:     w = fmt_s(3'd2, ra, rb, imm);
      MN_SD:     w = fmt_s(3'd3, ra, rb, imm);
      MN_LUI:    w = fmt_u(OPC_LUI, rd, imm);
      MN_AUIPC:  w = fmt_u(OPC_AUIPC, rd, imm);
      MN_FENCE:  w = {imm[11:0], 13'd0, OPC_MISC};
      MN_NOP:    w = fmt_i(OPC_OPI, F3_ADD, REG_ZERO, REG_ZERO, 32'd0);
      MN_LI, MN_LA: begin
        // upper part carries the rounding of the low 12 bits
        v = (r.opcode == MN_LI) ? imm : rel;
        e.machine_word = fmt_u((r.opcode == MN_LI) ? OPC_LUI : OPC_AUIPC, rd, v + 32'h800);
        e.last = 1'b0;
        expected_words.push_back(e);
        w = fmt_i(OPC_OPI, F3_ADD, rd, rd, v);
      end
      MN_MV:     w = fmt_i(OPC_OPI, F3_ADD, rd, ra, 32'd0);
      MN_NOT:    w = fmt_i(OPC_OPI, F3_XOR, rd, ra, 32'hFFF);
      MN_NEG:    w = fmt_r(OPC_OP, F3_ADD, F7_ALT, rd, REG_ZERO, ra);
      MN_NEGW:   w = fmt_r(OPC_OP32, F3_ADD, F7_ALT, rd, REG_ZERO, ra);
      MN_SEXT_W: w = fmt_i(OPC_OPI32, F3_ADD, rd, ra, 32'd0);
      MN_SEQZ:   w = fmt_i(OPC_OPI, F3_SLTU, rd, ra, 32'd1);
      MN_SNEZ:   w = fmt_r(OPC_OP, F3_SLTU, F7_NONE, rd, REG_ZERO, ra);
      MN_SLTZ:   w = fmt_r(OPC_OP, F3_SLT, F7_NONE, rd, ra, REG_ZERO);
      MN_SGTZ:   w = fmt_r(OPC_OP, F3_SLT, F7_NONE, rd, REG_ZERO, ra);
      MN_BEQZ:   w = fmt_b(F3_BEQ, ra, REG_ZERO, rel);
      MN_BNEZ:   w = fmt_b(F3_BNE, ra, REG_ZERO, rel);
      MN_BLEZ:   w = fmt_b(F3_BGE, REG_ZERO, ra, rel);
      MN_BGEZ:   w = fmt_b(F3_BGE, ra, REG_ZERO, rel);
      MN_BLTZ:   w = fmt_b(F3_BLT, ra, REG_ZERO, rel);
      MN_BGTZ:   w = fmt_b(F3_BLT, REG_ZERO, ra, rel);
      // swapped-operand branches
      MN_BGT:    w = fmt_b(F3_BLT, rb, ra, rel);
      MN_BLE:    w = fmt_b(F3_BGE, rb, ra, rel);
      MN_BGTU:   w = fmt_b(F3_BLTU, rb, ra, rel);
      MN_BLEU:   w = fmt_b(F3_BGEU, rb, ra, rel);
      default:   return;
    endcase
    e.machine_word = w;
    e.last = 1'b1;
    expected_words.push_back(e);
  endfunction

  function automatic req_word_t make_request(logic [6:0] code, logic [4:0] rd,
                                             logic [4:0] ra, logic [4:0] rb,
                                             logic [31:0] imm, logic [31:0] label,
                                             logic [31:0] pos);
    req_word_t r;
    r.opcode        = code;
    r.dest_reg      = rd;
    r.src_reg_a     = ra;
    r.src_reg_b     = rb;
    r.immediate     = imm;
    r.label_address = label;
    r.position      = pos;
    return r;
  endfunction

  // Random request; pairs_only restricts the code to li and la
  function automatic req_word_t random_request(bit pairs_only);
    req_word_t   r;
    logic [31:0] edges[7];
    edges = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FF, 32'h800,
              32'hFFFF_F7FF};
    r.opcode    = pairs_only ? ($urandom_range(0, 1) ? MN_LI : MN_LA)
                : ($urandom_range(0, 9) == 0) ? 7'($urandom_range(CODE_LIMIT, CODE_MAX))
                : 7'($urandom_range(0, MN_BLEU));
    r.dest_reg  = 5'($urandom);
    r.src_reg_a = 5'($urandom);
    r.src_reg_b = 5'($urandom);
    case ($urandom_range(0, 3))
      0: r.immediate = $urandom;
      1: r.immediate = $urandom_range(0, 4095) - 2048;
      2: r.immediate = edges[$urandom_range(0, 6)];
      default: r.immediate = $urandom_range(0, 63);
    endcase
    r.position = $urandom;
    case ($urandom_range(0, 2))
      0: r.label_address = $urandom;
      1: r.label_address = r.position + 2 * ($urandom_range(0, 4095) - 2048);
      default: r.label_address = r.position + 2 * ($urandom_range(0, 1048575) - 524288);
    endcase
    return r;
  endfunction

  // Offers one request word and waits until it is taken
  task automatic send_request(input req_word_t r);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_gaps && $urandom_range(0, 1)) gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= r;
    do @(posedge clk); while (in_stall);
    predict_words(r);
  endtask

  // Receiver stall pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_run == 0) begin
            stall_busy = !stall_busy;
            stall_run = stall_busy ? $urandom_range(1, 8) : $urandom_range(1, 4);
          end
          stall_run--;
          out_stall <= stall_busy;
        end
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: machine_word %h last %b", out_word.machine_word,
               out_word.last);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_word.machine_word !== want.machine_word) begin
          $error("machine_word: expected %h, got %h", want.machine_word,
                 out_word.machine_word);
          error_count++;
        end
        if (out_word.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_word.last);
          error_count++;
        end
      end
    end
  end

  // Field extremes, shift and immediate truncation, reach limits, carries, unknown codes
  task automatic test_directed_cases();
    sender_gaps = 1'b1;
    stall_mode  = STALL_RANDOM;
    send_request(make_request(MN_ADD, 5'd31, 5'd31, 5'd31, '1, '1, '0));
    send_request(make_request(MN_SUB, 5'd0, 5'd0, 5'd0, '0, '0, '0));
    send_request(make_request(MN_ADDI, 5'd1, 5'd2, 5'd3, 32'h7FFF_FFFF, '0, '0));
    send_request(make_request(MN_XORI, 5'd4, 5'd5, 5'd6, 32'h8000_0000, '0, '0));
    send_request(make_request(MN_SLLI, 5'd7, 5'd8, 5'd9, 32'hFFFF_FFFF, '0, '0));
    send_request(make_request(MN_SLLIW, 5'd10, 5'd11, 5'd12, 32'hFFFF_FFFF, '0, '0));
    send_request(make_request(MN_SRAI, 5'd13, 5'd14, 5'd15, 32'h3F, '0, '0));
    send_request(make_request(MN_SRAIW, 5'd16, 5'd17, 5'd18, 32'hFFFF_FFE0, '0, '0));
    send_request(make_request(MN_SD, 5'd0, 5'd1, 5'd31, 32'hFFFF_FFFF, '0, '0));
    send_request(make_request(MN_SB, 5'd31, 5'd30, 5'd29, 32'h800, '0, '0));
    send_request(make_request(MN_BEQ, 5'd3, 5'd1, 5'd2, '0, 32'h100, 32'h100));
    send_request(make_request(MN_BNE, 5'd3, 5'd31, 5'd31, '0, 32'hFFE, 32'h0));
    send_request(make_request(MN_BLT, 5'd3, 5'd4, 5'd5, '0, 32'h1001, 32'h0));
    send_request(make_request(MN_BGEU, 5'd3, 5'd6, 5'd7, '0, 32'h0, 32'h1000));
    send_request(make_request(MN_JAL, 5'd1, 5'd0, 5'd0, '0, 32'h000F_FFFE, 32'h0));
    send_request(make_request(MN_JAL, 5'd31, 5'd0, 5'd0, '0, 32'h8000_0001, 32'h0));
    send_request(make_request(MN_LI, 5'd5, 5'd0, 5'd0, 32'h800, '0, '0));
    send_request(make_request(MN_LI, 5'd6, 5'd0, 5'd0, 32'h7FFF_FFFF, '0, '0));
    send_request(make_request(MN_LI, 5'd7, 5'd0, 5'd0, 32'hFFFF_F7FF, '0, '0));
    send_request(make_request(MN_LA, 5'd31, 5'd0, 5'd0, '0, 32'hFFFF_FFFF, 32'h0));
    send_request(make_request(MN_LUI, 5'd31, 5'd0, 5'd0, 32'hFFFF_FFFF, '0, '0));
    send_request(make_request(MN_FENCE, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, '0, '0));
    send_request(make_request(MN_EBREAK, 5'd31, 5'd31, 5'd31, '1, '1, '0));
    send_request(make_request(CODE_LIMIT, 5'd1, 5'd1, 5'd1, '1, '1, '1));
    send_request(make_request(CODE_MAX, 5'd2, 5'd2, 5'd2, '0, '0, '0));
    send_request(make_request(MN_BLEU, 5'd0, 5'd31, 5'd1, '0, 32'h0, 32'h2));
  endtask

  // Every code, including the ones with no encoding, with random operands
  task automatic test_every_code();
    req_word_t r;
    for (int code = 0; code <= CODE_MAX; code++) begin
      r = random_request(1'b0);
      r.opcode = 7'(code);
      send_request(r);
    end
  endtask

  task automatic test_random_mix(input int count, input stall_mode_t mode, input bit gaps);
    stall_mode  = mode;
    sender_gaps = gaps;
    repeat (count) send_request(random_request(1'b0));
  endtask

  // Receiver holds off while li/la keep coming, so the queue fills and the input stalls
  task automatic test_output_hold_off();
    stall_mode   = STALL_NONE;
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    repeat (60) send_request(random_request(1'b1));
    repeat (40) send_request(random_request(1'b0));
  endtask

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_every_code();
    test_random_mix(400, STALL_RANDOM, 1'b1);
    test_random_mix(250, STALL_NONE, 1'b0);
    test_output_hold_off();
    test_random_mix(300, STALL_BURSTY, 1'b1);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("rv64i_instruction_encoder_top_tb: done, clean");
    end else begin
      $display("rv64i_instruction_encoder_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("rv64i_instruction_encoder_top_tb: done, errors");
    $finish;
  end

endmodule
